>>> sv/ppnfd_pkg.sv
// Shared types and constants of the particle slot pool.
package ppnfd_pkg;

    // Default pool depth
    localparam int POOL_DEPTH_DEF = 256;

    // Life value of a freshly added particle, Q1.15
    localparam logic [15:0] LIFE_ONE = 16'h8000;

    // Width of the shared subtract unit
    localparam int SUB_W = 32;

    // Opcodes
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Configuration register indexes
    localparam logic REG_SLOTS_IN_USE = 1'b0;
    localparam logic REG_DECAY_RATE   = 1'b1;

    // Configuration reset values
    localparam logic [8:0]  SLOTS_RESET = 9'd256;
    localparam logic [15:0] RATE_RESET  = 16'd256;

    // Stored particle record
    typedef struct packed {
        logic        [15:0] size;
        logic        [31:0] color;
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_x;
    } t_rec;

endpackage

>>> sv/particle_pool_next_fit_decay_top.sv
// Particle slot pool with next-fit allocation and lifetime decay.
//
// Input channel (i_in_valid / o_in_ready) takes one command per transaction:
// add a particle, tick time, or read a slot. Output channel (o_out_valid /
// i_out_ready) returns one result for add and read; tick and the unused
// opcode return nothing. Configuration is a plain write port (i_cfg_we,
// i_cfg_index, i_cfg_data): write only while the block is idle (not checked).
// Work is done by one sequencer over a life memory with one read and one
// write port, visiting one slot per cycle, and one shared subtractor.
//   add : scans up to n slots (n = slots in use, clamped to the pool depth);
//         the search scan stops early at the first free slot.
//   tick: one multiply step, then one slot per cycle over n slots.
//   read: index reduced by repeated subtraction of POOL_DEPTH, then one
//         memory read.
// After reset the life memory is cleared by a pass over all POOL_DEPTH slots;
// o_in_ready stays low during it. Configuration returns to its reset values.
// A finished result waits in the output register while the receiver stalls;
// the next command is accepted meanwhile, and it completes once the output
// register is free.
module particle_pool_next_fit_decay_top #(
    parameter int POOL_DEPTH = ppnfd_pkg::POOL_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic        [15:0] i_cfg_data,
    // command channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic        [1:0]  i_opcode,
    input  logic        [15:0] i_delta_time,
    input  logic        [7:0]  i_read_slot,
    input  logic signed [15:0] i_new_pos_x,
    input  logic signed [15:0] i_new_pos_y,
    input  logic signed [15:0] i_new_vel_x,
    input  logic signed [15:0] i_new_vel_y,
    input  logic        [31:0] i_new_color,
    input  logic        [15:0] i_new_size,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic        [7:0]  o_slot_index,
    output logic               o_slot_active,
    output logic        [15:0] o_life_left,
    output logic signed [15:0] o_out_pos_x,
    output logic signed [15:0] o_out_pos_y,
    output logic signed [15:0] o_out_vel_x,
    output logic signed [15:0] o_out_vel_y,
    output logic        [31:0] o_out_color,
    output logic        [15:0] o_out_size
);
    import ppnfd_pkg::*;

    localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int NW = (CW > 9) ? CW : 9;

    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_MUL    = 9'b000000100,
        ST_TICK   = 9'b000001000,
        ST_SEARCH = 9'b000010000,
        ST_WRITE  = 9'b000100000,
        ST_RMOD   = 9'b001000000,
        ST_RREAD  = 9'b010000000,
        ST_DONE   = 9'b100000000
    } t_state;

    // memories
    logic [15:0] life_mem [POOL_DEPTH];
    t_rec        rec_mem  [POOL_DEPTH];

    t_state      r_state, n_state;
    logic [8:0]  r_slots;
    logic [15:0] r_rate;
    logic [1:0]  r_op;
    logic [15:0] r_dt;
    t_rec        r_rec;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_left, n_left;
    logic        r_chk_v, n_chk_v;
    logic [AW-1:0] r_chk_addr, n_chk_addr;
    logic [AW-1:0] r_slot, n_slot;
    logic [AW-1:0] r_search_start, n_search_start;
    logic [7:0]  r_mod, n_mod;
    logic [30:0] r_dec;
    logic [15:0] r_life_rd;
    t_rec        r_rec_rd;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_index;
    logic        r_out_active;
    logic [15:0] r_out_life;
    t_rec        r_out_rec;

    logic          w_accept;
    logic [CW-1:0] w_n;
    logic [CW-1:0] w_ptr_inc;
    logic [CW-1:0] w_start;
    logic [31:0]   w_prod;
    logic [SUB_W-1:0] w_sub_a, w_sub_b;
    logic [SUB_W:0]   w_sub;
    logic          w_borrow;
    logic          w_life_we, w_life_re;
    logic [AW-1:0] w_life_waddr, w_life_raddr;
    logic [15:0]   w_life_wdata;
    logic          w_rec_we, w_rec_re;
    logic          w_load;

    assign w_accept = i_in_valid && o_in_ready;

    // Clamp slots in use to the pool depth
    always_comb begin
        if (NW'(r_slots) > NW'(POOL_DEPTH)) begin
            w_n = CW'(POOL_DEPTH);
        end else begin
            w_n = CW'(r_slots);
        end
    end

    // Scan address step, wrapping at the slots in use
    assign w_ptr_inc = (r_ptr + CW'(1) == w_n) ? '0 : r_ptr + CW'(1);
    assign w_start   = (CW'(r_search_start) < w_n) ? CW'(r_search_start) : '0;

    // Rate times delta time; the decrement per tick is half of it
    assign w_prod = 32'(r_rate) * 32'(r_dt);

    // Shared subtractor: life minus decrement, or index minus pool depth
    always_comb begin
        w_sub_a = '0;
        w_sub_b = '0;
        if (r_state == ST_TICK) begin
            w_sub_a = SUB_W'(r_life_rd);
            w_sub_b = SUB_W'(r_dec);
        end else if (r_state == ST_RMOD) begin
            w_sub_a = SUB_W'(r_mod);
            w_sub_b = SUB_W'(POOL_DEPTH);
        end
    end
    assign w_sub    = {1'b0, w_sub_a} - {1'b0, w_sub_b};
    assign w_borrow = w_sub[SUB_W];

    // Sequencer
    always_comb begin
        n_state        = r_state;
        n_ptr          = r_ptr;
        n_left         = r_left;
        n_chk_v        = 1'b0;
        n_chk_addr     = r_chk_addr;
        n_slot         = r_slot;
        n_search_start = r_search_start;
        n_mod          = r_mod;
        w_life_we      = 1'b0;
        w_life_waddr   = r_slot;
        w_life_wdata   = '0;
        w_life_re      = 1'b0;
        w_life_raddr   = r_slot;
        w_rec_we       = 1'b0;
        w_rec_re       = 1'b0;
        w_load         = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                w_life_we    = 1'b1;
                w_life_waddr = r_ptr[AW-1:0];
                n_ptr        = r_ptr + CW'(1);
                if (r_ptr[AW-1:0] == AW'(POOL_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_opcode)
                        OP_ADD: begin
                            n_ptr   = w_start;
                            n_left  = w_n;
                            n_state = ST_SEARCH;
                        end
                        OP_TICK: begin
                            n_ptr   = '0;
                            n_left  = w_n;
                            n_state = ST_MUL;
                        end
                        OP_READ: begin
                            n_mod   = i_read_slot;
                            n_state = ST_RMOD;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                n_state = ST_TICK;
            end
            ST_TICK: begin
                // issue the next slot read, write back the previous one
                if (r_left != '0) begin
                    w_life_re    = 1'b1;
                    w_life_raddr = r_ptr[AW-1:0];
                    n_chk_v      = 1'b1;
                    n_chk_addr   = r_ptr[AW-1:0];
                    n_ptr        = w_ptr_inc;
                    n_left       = r_left - CW'(1);
                end
                if (r_chk_v && (r_life_rd != '0)) begin
                    w_life_we    = 1'b1;
                    w_life_waddr = r_chk_addr;
                    w_life_wdata = w_borrow ? '0 : w_sub[15:0];
                end
                if ((r_left == '0) && !r_chk_v) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SEARCH: begin
                if (r_left != '0) begin
                    w_life_re    = 1'b1;
                    w_life_raddr = r_ptr[AW-1:0];
                    n_chk_v      = 1'b1;
                    n_chk_addr   = r_ptr[AW-1:0];
                    n_ptr        = w_ptr_inc;
                    n_left       = r_left - CW'(1);
                end
                if (r_chk_v && (r_life_rd == '0)) begin
                    n_slot         = r_chk_addr;
                    n_search_start = r_chk_addr;
                    n_state        = ST_WRITE;
                end else if ((r_left == '0) && !r_chk_v) begin
                    // pool full: overwrite slot 0
                    n_slot  = '0;
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                w_life_we    = 1'b1;
                w_life_waddr = r_slot;
                w_life_wdata = LIFE_ONE;
                w_rec_we     = 1'b1;
                n_state      = ST_DONE;
            end
            ST_RMOD: begin
                if (!w_borrow) begin
                    n_mod = w_sub[7:0];
                end else begin
                    n_slot  = AW'(r_mod);
                    n_state = ST_RREAD;
                end
            end
            ST_RREAD: begin
                w_life_re = 1'b1;
                w_rec_re  = 1'b1;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold the result until taken
    assign n_out_valid = w_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_ptr          <= '0;
            r_left         <= '0;
            r_chk_v        <= 1'b0;
            r_search_start <= '0;
            r_out_valid    <= 1'b0;
            r_slots        <= SLOTS_RESET;
            r_rate         <= RATE_RESET;
        end else begin
            r_state        <= n_state;
            r_ptr          <= n_ptr;
            r_left         <= n_left;
            r_chk_v        <= n_chk_v;
            r_search_start <= n_search_start;
            r_out_valid    <= n_out_valid;
            if (i_cfg_we && (i_cfg_index == REG_SLOTS_IN_USE)) begin
                r_slots <= i_cfg_data[8:0];
            end
            if (i_cfg_we && (i_cfg_index == REG_DECAY_RATE)) begin
                r_rate <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_chk_addr <= n_chk_addr;
        r_slot     <= n_slot;
        r_mod      <= n_mod;
        if (w_accept) begin
            r_op         <= i_opcode;
            r_dt         <= i_delta_time;
            r_rec.pos_x  <= i_new_pos_x;
            r_rec.pos_y  <= i_new_pos_y;
            r_rec.vel_x  <= i_new_vel_x;
            r_rec.vel_y  <= i_new_vel_y;
            r_rec.color  <= i_new_color;
            r_rec.size   <= i_new_size;
        end
        if (r_state == ST_MUL) begin
            r_dec <= w_prod[31:1];
        end
        if (w_load) begin
            r_out_index <= 8'(r_slot);
            if (r_op == OP_ADD) begin
                r_out_active <= 1'b1;
                r_out_life   <= LIFE_ONE;
                r_out_rec    <= r_rec;
            end else begin
                r_out_active <= (r_life_rd != '0);
                r_out_life   <= r_life_rd;
                r_out_rec    <= (r_life_rd != '0) ? r_rec_rd : '0;
            end
        end
    end

    // Life memory
    always_ff @(posedge i_clk) begin
        if (w_life_we) begin
            life_mem[w_life_waddr] <= w_life_wdata;
        end
        if (w_life_re) begin
            r_life_rd <= life_mem[w_life_raddr];
        end
    end

    // Record memory
    always_ff @(posedge i_clk) begin
        if (w_rec_we) begin
            rec_mem[r_slot] <= r_rec;
        end
        if (w_rec_re) begin
            r_rec_rd <= rec_mem[r_slot];
        end
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_slot_index  = r_out_index;
    assign o_slot_active = r_out_active;
    assign o_life_left   = r_out_life;
    assign o_out_pos_x   = r_out_rec.pos_x;
    assign o_out_pos_y   = r_out_rec.pos_y;
    assign o_out_vel_x   = r_out_rec.vel_x;
    assign o_out_vel_y   = r_out_rec.vel_y;
    assign o_out_color   = r_out_rec.color;
    assign o_out_size    = r_out_rec.size;

    // An accepted add, tick or read takes the sequencer out of idle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && ((i_opcode == OP_ADD) || (i_opcode == OP_TICK) ||
                      (i_opcode == OP_READ))) |=> !o_in_ready)
        else $error("command accepted while sequencer stays ready");

    // No memory writes while idle
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !(w_life_we || w_rec_we))
        else $error("memory write while idle");

    // A new result appears only from the completion step
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_DONE) |=> !$rose(o_out_valid))
        else $error("result raised outside completion");

    // Search start stays inside the pool
    a_start_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_search_start <= AW'(POOL_DEPTH - 1))
        else $error("search start beyond pool");

endmodule

>>> test/testbench.sv
// Self-checking testbench for the next-fit particle slot pool with lifetime decay.
`timescale 1ns / 100ps

module testbench;
    import ppnfd_pkg::*;

    localparam int POOL_SLOTS     = POOL_DEPTH_DEF;
    localparam int RANDOM_ITEMS   = 550;
    localparam int SETTLE_CYCLES  = 300;
    localparam int LONG_HOLD      = 700;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One command as offered on the input channel, plus the sender's gap before it
    typedef struct {
        logic [1:0]  op;
        logic [15:0] dt;
        logic [7:0]  slot;
        t_rec        rec;
        int          gap;
    } t_pool_cmd;

    // One slot report as returned on the output channel
    typedef struct packed {
        logic [7:0]  slot;
        logic        active;
        logic [15:0] life;
        t_rec        rec;
    } t_slot_report;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_index = 1'b0;
    logic        [15:0] i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic        [1:0]  i_opcode = '0;
    logic        [15:0] i_delta_time = '0;
    logic        [7:0]  i_read_slot = '0;
    logic signed [15:0] i_new_pos_x = '0;
    logic signed [15:0] i_new_pos_y = '0;
    logic signed [15:0] i_new_vel_x = '0;
    logic signed [15:0] i_new_vel_y = '0;
    logic        [31:0] i_new_color = '0;
    logic        [15:0] i_new_size = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic        [7:0]  o_slot_index;
    logic               o_slot_active;
    logic        [15:0] o_life_left;
    logic signed [15:0] o_out_pos_x;
    logic signed [15:0] o_out_pos_y;
    logic signed [15:0] o_out_vel_x;
    logic signed [15:0] o_out_vel_y;
    logic        [31:0] o_out_color;
    logic        [15:0] o_out_size;

    // Predicted pool contents and configuration
    logic [15:0] pool_life [POOL_SLOTS];
    t_rec        pool_rec [POOL_SLOTS];
    int unsigned next_fit_start;
    logic [8:0]  model_slots;
    logic [15:0] model_rate;

    t_pool_cmd    commands_waiting[$];
    t_slot_report due_reports[$];

    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    int   gap_left = 0;
    bit   gap_loaded = 1'b0;
    int   stall_left = 0;
    bit   long_hold_done = 1'b0;
    int   reports_seen = 0;
    int   failures = 0;
    int   quiet_cycles = 0;
    int   calm_left [2] = '{0, 0};

    particle_pool_next_fit_decay_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_delta_time (i_delta_time),
        .i_read_slot  (i_read_slot),
        .i_new_pos_x  (i_new_pos_x),
        .i_new_pos_y  (i_new_pos_y),
        .i_new_vel_x  (i_new_vel_x),
        .i_new_vel_y  (i_new_vel_y),
        .i_new_color  (i_new_color),
        .i_new_size   (i_new_size),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_slot_index (o_slot_index),
        .o_slot_active(o_slot_active),
        .o_life_left  (o_life_left),
        .o_out_pos_x  (o_out_pos_x),
        .o_out_pos_y  (o_out_pos_y),
        .o_out_vel_x  (o_out_vel_x),
        .o_out_vel_y  (o_out_vel_y),
        .o_out_color  (o_out_color),
        .o_out_size   (o_out_size)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Draw an idle count; side 0 is the sender, side 1 the receiver.
    // Now and then start a run of back-to-back transactions.
    function automatic int draw_wait(int side);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm_left[side] = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // Command with random content in every field; callers override what matters
    function automatic t_pool_cmd blank_cmd(logic [1:0] op);
        t_pool_cmd c;
        c.op        = op;
        c.dt        = 16'($urandom);
        c.slot      = 8'($urandom);
        c.rec.pos_x = 16'($urandom);
        c.rec.pos_y = 16'($urandom);
        c.rec.vel_x = 16'($urandom);
        c.rec.vel_y = 16'($urandom);
        c.rec.color = $urandom;
        c.rec.size  = 16'($urandom);
        c.gap       = draw_wait(0);
        return c;
    endfunction

    // Report of one slot; an idle slot shows zero life and an empty record
    function automatic t_slot_report slot_report(int unsigned s);
        t_slot_report r;
        r = '0;
        r.slot = s[7:0];
        if (pool_life[s] != 0) begin
            r.active = 1'b1;
            r.life   = pool_life[s];
            r.rec    = pool_rec[s];
        end
        return r;
    endfunction

    // Advance the predicted pool by one accepted command
    task automatic apply_command(input t_pool_cmd cmd);
        int unsigned n;
        int unsigned scan;
        int unsigned wrap_end;
        int unsigned found;
        bit          hit;
        logic [31:0] drop;
        n = (model_slots > POOL_SLOTS) ? POOL_SLOTS : model_slots;
        case (cmd.op)
            OP_ADD: begin
                // next-fit: from the last hit to the end, then wrap; full pool takes slot 0
                found = 0;
                hit = 1'b0;
                for (scan = next_fit_start; scan < n && !hit; scan++) begin
                    if (pool_life[scan] == 0) begin
                        found = scan;
                        hit = 1'b1;
                    end
                end
                wrap_end = (next_fit_start < n) ? next_fit_start : n;
                for (scan = 0; scan < wrap_end && !hit; scan++) begin
                    if (pool_life[scan] == 0) begin
                        found = scan;
                        hit = 1'b1;
                    end
                end
                if (hit)
                    next_fit_start = found;
                pool_life[found] = LIFE_ONE;
                pool_rec[found]  = cmd.rec;
                due_reports.push_back(slot_report(found));
            end
            OP_TICK: begin
                // decay live slots, saturating at zero
                drop = (32'(model_rate) * 32'(cmd.dt)) >> 1;
                for (scan = 0; scan < n; scan++) begin
                    if (pool_life[scan] != 0)
                        pool_life[scan] = (32'(pool_life[scan]) > drop) ?
                                          pool_life[scan] - drop[15:0] : 16'd0;
                end
            end
            OP_READ: begin
                due_reports.push_back(slot_report(cmd.slot % POOL_SLOTS));
            end
            default: begin
            end
        endcase
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    // Write one register while the pool is idle, and mirror it in the prediction
    task automatic write_reg(input logic idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_SLOTS_IN_USE)
            model_slots = data[8:0];
        else
            model_rate = data;
    endtask

    // Wait for every command and report to drain, then for the longest sweep
    task automatic settle();
        while (commands_waiting.size() != 0 || i_in_valid || due_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Capture accepted commands and advance the prediction
    always @(posedge i_clk) begin : cmd_accept
        t_pool_cmd got;
        if (i_rst_n && i_in_valid && o_in_ready === 1'b1) begin
            got.op        = i_opcode;
            got.dt        = i_delta_time;
            got.slot      = i_read_slot;
            got.rec.pos_x = i_new_pos_x;
            got.rec.pos_y = i_new_pos_y;
            got.rec.vel_x = i_new_vel_x;
            got.rec.vel_y = i_new_vel_y;
            got.rec.color = i_new_color;
            got.rec.size  = i_new_size;
            got.gap       = 0;
            apply_command(got);
            in_taken <= 1'b1;
        end else begin
            in_taken <= 1'b0;
        end
    end

    // Drive commands from the queue, holding each until the transaction completes
    always @(negedge i_clk) begin : cmd_driver
        t_pool_cmd cmd;
        if (!i_in_valid || in_taken) begin
            if (!gap_loaded && commands_waiting.size() != 0) begin
                gap_left   = commands_waiting[0].gap;
                gap_loaded = 1'b1;
            end
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (commands_waiting.size() != 0) begin
                cmd = commands_waiting.pop_front();
                i_opcode     <= cmd.op;
                i_delta_time <= cmd.dt;
                i_read_slot  <= cmd.slot;
                i_new_pos_x  <= cmd.rec.pos_x;
                i_new_pos_y  <= cmd.rec.pos_y;
                i_new_vel_x  <= cmd.rec.vel_x;
                i_new_vel_y  <= cmd.rec.vel_y;
                i_new_color  <= cmd.rec.color;
                i_new_size   <= cmd.rec.size;
                i_in_valid   <= 1'b1;
                gap_loaded   = 1'b0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Stall the result channel; once, hold off long enough to back up the input
    always @(negedge i_clk) begin : result_receiver
        if (out_taken) begin
            if (!long_hold_done && reports_seen >= 60 && commands_waiting.size() > 8) begin
                stall_left     = LONG_HOLD;
                long_hold_done = 1'b1;
            end else begin
                stall_left = draw_wait(1);
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each accepted report with the oldest prediction
    always @(posedge i_clk) begin : report_monitor
        t_slot_report want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            reports_seen++;
            if (due_reports.size() == 0) begin
                $error("report for slot %0h arrived with none predicted", o_slot_index);
                failures++;
            end else begin
                want = due_reports.pop_front();
                check_field("slot_index", 32'(want.slot), 32'(o_slot_index));
                check_field("slot_active", 32'(want.active), 32'(o_slot_active));
                check_field("life_left", 32'(want.life), 32'(o_life_left));
                check_field("out_pos_x", 32'(want.rec.pos_x), 32'(o_out_pos_x));
                check_field("out_pos_y", 32'(want.rec.pos_y), 32'(o_out_pos_y));
                check_field("out_vel_x", 32'(want.rec.vel_x), 32'(o_out_vel_x));
                check_field("out_vel_y", 32'(want.rec.vel_y), 32'(o_out_vel_y));
                check_field("out_color", want.rec.color, o_out_color);
                check_field("out_size", 32'(want.rec.size), 32'(o_out_size));
            end
            out_taken <= 1'b1;
        end else begin
            out_taken <= 1'b0;
        end
    end

    // Abort if no transaction moves for too long
    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus: directed phases, then random phases under random configuration
    initial begin : stimulus
        t_pool_cmd   c;
        int          random_items;
        int          phase_len;
        int          pick;
        int unsigned n_eff;
        int unsigned dt_max;
        logic [8:0]  slots_pick;
        logic [15:0] rate_pick;

        for (int i = 0; i < POOL_SLOTS; i++)
            pool_life[i] = '0;
        next_fit_start = 0;
        model_slots    = SLOTS_RESET;
        model_rate     = RATE_RESET;
        random_items   = 0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty pool: first and last slot read back idle
        c = blank_cmd(OP_READ); c.slot = 8'd0;   commands_waiting.push_back(c);
        c = blank_cmd(OP_READ); c.slot = 8'd255; commands_waiting.push_back(c);
        // adds with record fields at their extremes
        c = blank_cmd(OP_ADD);
        c.rec.pos_x = 16'h8000; c.rec.pos_y = 16'h7FFF; c.rec.vel_x = 16'hFFFF;
        c.rec.vel_y = 16'h0000; c.rec.color = 32'hFFFF_FFFF; c.rec.size = 16'h0000;
        commands_waiting.push_back(c);
        c = blank_cmd(OP_ADD);
        c.rec.pos_x = 16'h7FFF; c.rec.pos_y = 16'h8000; c.rec.vel_x = 16'h0000;
        c.rec.vel_y = 16'h8000; c.rec.color = 32'h0000_0000; c.rec.size = 16'hFFFF;
        commands_waiting.push_back(c);
        c = blank_cmd(OP_READ); c.slot = 8'd0; commands_waiting.push_back(c);
        c = blank_cmd(OP_READ); c.slot = 8'd1; commands_waiting.push_back(c);
        // zero tick, then a small one
        c = blank_cmd(OP_TICK); c.dt = 16'd0; commands_waiting.push_back(c);
        c = blank_cmd(OP_READ); c.slot = 8'd0; commands_waiting.push_back(c);
        c = blank_cmd(OP_TICK); c.dt = 16'd1; commands_waiting.push_back(c);
        c = blank_cmd(OP_READ); c.slot = 8'd1; commands_waiting.push_back(c);
        // unused opcode is dropped
        c = blank_cmd(OP_UNUSED); commands_waiting.push_back(c);
        // oversized decrement frees every slot
        c = blank_cmd(OP_TICK); c.dt = 16'hFFFF; commands_waiting.push_back(c);
        c = blank_cmd(OP_READ); c.slot = 8'd0; commands_waiting.push_back(c);
        c = blank_cmd(OP_ADD); commands_waiting.push_back(c);
        c = blank_cmd(OP_ADD); commands_waiting.push_back(c);
        settle();

        // one slot in use, search start past it, then a full pool
        write_reg(REG_SLOTS_IN_USE, 16'd1);
        write_reg(REG_DECAY_RATE, 16'hFFFF);
        c = blank_cmd(OP_ADD);  commands_waiting.push_back(c);
        c = blank_cmd(OP_ADD);  commands_waiting.push_back(c);
        c = blank_cmd(OP_TICK); c.dt = 16'd1; commands_waiting.push_back(c);
        c = blank_cmd(OP_READ); c.slot = 8'd0; commands_waiting.push_back(c);
        c = blank_cmd(OP_TICK); c.dt = 16'd1; commands_waiting.push_back(c);
        c = blank_cmd(OP_READ); c.slot = 8'd0; commands_waiting.push_back(c);
        settle();

        // no slots in use: add lands on slot 0 and nothing decays
        write_reg(REG_SLOTS_IN_USE, 16'd0);
        c = blank_cmd(OP_ADD);  commands_waiting.push_back(c);
        c = blank_cmd(OP_TICK); c.dt = 16'd7; commands_waiting.push_back(c);
        c = blank_cmd(OP_READ); c.slot = 8'd0; commands_waiting.push_back(c);
        settle();

        // count beyond the pool is clamped; zero rate keeps life
        write_reg(REG_SLOTS_IN_USE, 16'hFFFF);
        write_reg(REG_DECAY_RATE, 16'd0);
        c = blank_cmd(OP_ADD);  commands_waiting.push_back(c);
        c = blank_cmd(OP_TICK); c.dt = 16'hFFFF; commands_waiting.push_back(c);
        c = blank_cmd(OP_READ); c.slot = 8'd1; commands_waiting.push_back(c);
        settle();

        // random phases, each under a fresh configuration
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       slots_pick = 9'd0;
                1:       slots_pick = 9'd1;
                2, 3:    slots_pick = 9'($urandom_range(2, 8));
                4:       slots_pick = 9'($urandom_range(9, 64));
                5:       slots_pick = 9'($urandom_range(65, 255));
                6:       slots_pick = 9'd256;
                7:       slots_pick = 9'($urandom_range(257, 511));
                default: slots_pick = 9'($urandom_range(2, 16));
            endcase
            case ($urandom_range(0, 5))
                0:       rate_pick = 16'd0;
                1:       rate_pick = 16'hFFFF;
                2:       rate_pick = 16'($urandom_range(1, 255));
                3:       rate_pick = 16'd256;
                default: rate_pick = 16'($urandom);
            endcase
            write_reg(REG_SLOTS_IN_USE, {7'($urandom), slots_pick});
            write_reg(REG_DECAY_RATE, rate_pick);

            n_eff     = (model_slots > POOL_SLOTS) ? POOL_SLOTS : model_slots;
            dt_max    = (model_rate == 0) ? 65535 : 8192 / model_rate;
            phase_len = $urandom_range(30, 70);
            for (int k = 0; k < phase_len; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    c = blank_cmd(OP_ADD);
                end else if (pick < 55) begin
                    // keep most decrements mild so particles survive a few ticks
                    c = blank_cmd(OP_TICK);
                    if ($urandom_range(0, 9) != 0)
                        c.dt = 16'($urandom_range(0, dt_max));
                end else if (pick < 95) begin
                    c = blank_cmd(OP_READ);
                    if (n_eff > 0 && $urandom_range(0, 4) != 0)
                        c.slot = 8'($urandom_range(0, n_eff - 1));
                end else begin
                    c = blank_cmd(OP_UNUSED);
                end
                commands_waiting.push_back(c);
                if (c.op != OP_UNUSED)
                    random_items++;
            end
            settle();
        end

        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
sv/ppnfd_pkg.sv
sv/particle_pool_next_fit_decay_top.sv
test/testbench.sv
